/* rtl/core/bcmf_pkg.sv */
// ----------------------------------------------------------------------------
// bcmf_pkg
// Shared types, constants and helpers of the binary cross majority filter.
// ----------------------------------------------------------------------------
package bcmf_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [WIDTH_REG_W-1:0]  RESET_IMAGE_WIDTH  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] RESET_IMAGE_HEIGHT = 16'd1024;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic cmd;
      logic pixel_in;
   } req_type;

   typedef struct packed {
      logic pixel_out;
      logic end_of_frame;
   } rsp_type;

   // one line store entry: pixel of the middle row and of the row above it
   typedef struct packed {
      logic mid;
      logic top;
   } line_entry_type;

   // control of one transaction between the counter stage and the vote stage
   typedef struct packed {
      logic emit;
      logic pixel;
      logic has_up;
      logic has_left;
      logic has_down;
      logic has_right;
      logic eof;
   } item_ctl_type;

   // last column index for a programmed width, width clamped to 1..max_width
   function automatic int unsigned last_col_of(logic [WIDTH_REG_W-1:0] width,
                                               int unsigned max_width);
      int unsigned w;
      w = 32'(width);
      if (w == 0) w = 1;
      if (w > max_width) w = max_width;
      return w - 1;
   endfunction

   // last row index for a programmed height, zero acts as one
   function automatic logic [HEIGHT_REG_W-1:0] last_row_of(
      logic [HEIGHT_REG_W-1:0] height);
      logic [HEIGHT_REG_W-1:0] h;
      h = (height == '0) ? HEIGHT_REG_W'(1) : height;
      return h - HEIGHT_REG_W'(1);
   endfunction

endpackage

/* rtl/core/bcmf_line_mem.sv */
// ----------------------------------------------------------------------------
// bcmf_line_mem
// Combined upper/middle line store, one write and one registered read port,
// with the write data bypassed to a read of the same address.
// ----------------------------------------------------------------------------
module bcmf_line_mem #(
   parameter int MAX_WIDTH = bcmf_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  bcmf_pkg::line_entry_type      wr_data,
   output bcmf_pkg::line_entry_type      rd_data
);

   bcmf_pkg::line_entry_type line_store_ff [MAX_WIDTH];
   bcmf_pkg::line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store_ff[wr_addr] <= wr_data;
      end
   end

   // a one-pixel-wide image reads the entry written in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= line_store_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bcmf_ctrl.sv */
// ----------------------------------------------------------------------------
// bcmf_ctrl
// Image size registers, input and output position counters and the stage
// register that carries each transaction to the vote stage.
// ----------------------------------------------------------------------------
module bcmf_ctrl #(
   parameter int MAX_WIDTH = bcmf_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [bcmf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bcmf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  en,
   input  logic                                  accept,
   input  bcmf_pkg::req_type                     req_data,
   output logic [$clog2(MAX_WIDTH)-1:0]          rd_col,
   output logic                                  s1_valid,
   output bcmf_pkg::item_ctl_type                s1_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]          s1_col
);

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = bcmf_pkg::HEIGHT_REG_W;
   // input row runs up to one past the height while results drain
   localparam int IN_ROW_W = ROW_W + 1;

   logic [COL_W-1:0]    last_col_ff, last_col_in;
   logic [ROW_W-1:0]    last_row_ff, last_row_in;
   logic [COL_W-1:0]    in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]    out_col_ff, out_col_in;
   logic [ROW_W-1:0]    out_row_ff, out_row_in;
   logic                s1_valid_ff, s1_valid_in;
   bcmf_pkg::item_ctl_type s1_ctl_ff, s1_ctl_in;
   logic [COL_W-1:0]    s1_col_ff;

   logic past_end;
   logic ignore;
   logic emit;
   logic out_col_end;
   logic out_row_end;
   logic eof;

   always_comb begin
      past_end    = in_row_ff > {1'b0, last_row_ff};
      // drain tick before the last pixel does nothing
      ignore      = req_data.cmd && !past_end;
      emit        = (in_row_ff >= IN_ROW_W'(2)) ||
                    ((in_row_ff == IN_ROW_W'(1)) && (in_col_ff != '0));
      out_col_end = out_col_ff == last_col_ff;
      out_row_end = out_row_ff == last_row_ff;
      eof         = out_row_end && out_col_end;

      s1_ctl_in.emit      = emit;
      s1_ctl_in.pixel     = req_data.pixel_in && !req_data.cmd && !past_end;
      s1_ctl_in.has_up    = out_row_ff != '0;
      s1_ctl_in.has_left  = out_col_ff != '0;
      s1_ctl_in.has_down  = !out_row_end;
      s1_ctl_in.has_right = !out_col_end;
      s1_ctl_in.eof       = eof;
   end

   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      s1_valid_in = s1_valid_ff;

      if (en) begin
         s1_valid_in = accept && !ignore;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            bcmf_pkg::CSR_IMAGE_WIDTH: begin
               last_col_in = COL_W'(bcmf_pkg::last_col_of(
                  csr_wdata[bcmf_pkg::WIDTH_REG_W-1:0], MAX_WIDTH));
            end
            bcmf_pkg::CSR_IMAGE_HEIGHT: begin
               last_row_in = bcmf_pkg::last_row_of(
                  csr_wdata[bcmf_pkg::HEIGHT_REG_W-1:0]);
            end
         endcase
         // restart the frame
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept && !ignore) begin
         if (emit && eof) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (in_col_ff == last_col_ff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + IN_ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (emit) begin
               if (out_col_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= COL_W'(bcmf_pkg::last_col_of(bcmf_pkg::RESET_IMAGE_WIDTH,
                                                     MAX_WIDTH));
         last_row_ff <= bcmf_pkg::last_row_of(bcmf_pkg::RESET_IMAGE_HEIGHT);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ctl_ff <= s1_ctl_in;
         s1_col_ff <= in_col_ff;
      end
   end

   assign rd_col   = in_col_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_ctl   = s1_ctl_ff;
   assign s1_col   = s1_col_ff;

endmodule

/* rtl/core/bcmf_vote.sv */
// ----------------------------------------------------------------------------
// bcmf_vote
// Window taps, four-neighbour majority vote and the result register.
// ----------------------------------------------------------------------------
module bcmf_vote (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      s1_valid,
   input  bcmf_pkg::item_ctl_type    s1_ctl,
   input  bcmf_pkg::line_entry_type  line_rd,
   output bcmf_pkg::line_entry_type  line_wr,
   output logic                      rsp_valid,
   output bcmf_pkg::rsp_type         rsp_data
);

   // tap bits: [2] lower row, [1] middle row, [0] upper row
   logic [2:0] tap_a_ff;
   logic [2:0] tap_b_ff;
   logic [2:0] tap_new;

   logic       rsp_valid_ff;
   bcmf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [2:0] black;
   logic [2:0] white;
   logic       advance;

   always_comb begin
      advance = en && s1_valid;
      tap_new = {s1_ctl.pixel, line_rd.mid, line_rd.top};

      // middle row moves up, new pixel becomes the middle row
      line_wr.mid = s1_ctl.pixel;
      line_wr.top = line_rd.mid;

      black = 3'(s1_ctl.has_up    &&  tap_b_ff[0]) +
              3'(s1_ctl.has_left  &&  tap_a_ff[1]) +
              3'(s1_ctl.has_down  &&  tap_b_ff[2]) +
              3'(s1_ctl.has_right &&  tap_new[1]);
      white = 3'(s1_ctl.has_up    && !tap_b_ff[0]) +
              3'(s1_ctl.has_left  && !tap_a_ff[1]) +
              3'(s1_ctl.has_down  && !tap_b_ff[2]) +
              3'(s1_ctl.has_right && !tap_new[1]);

      if (black > 3'd2) begin
         rsp_data_in.pixel_out = 1'b1;
      end else if (white > 3'd2) begin
         rsp_data_in.pixel_out = 1'b0;
      end else begin
         rsp_data_in.pixel_out = tap_b_ff[1];
      end
      rsp_data_in.end_of_frame = s1_ctl.eof;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tap_a_ff <= tap_b_ff;
         tap_b_ff <= tap_new;
      end
      if (advance && s1_ctl.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s1_valid && s1_ctl.emit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/binary_cross_majority_filter.sv */
// Path: a transaction enters the stage register at acceptance; its result goes
// from the stage register into the output register, W+1 transactions after its pixel.
// Throughput: one transaction per cycle, the line store takes one read and one
// write per cycle; the input stalls only while a result waits.
// Reset (synchronous): counters, valids and size registers (1024 x 1024) clear;
// line store and taps are not cleared, stale entries feed only absent neighbors.
// ----------------------------------------------------------------------------
// binary_cross_majority_filter
// Four-neighbour majority filter over a raster-order binary image with a combined
// two-row line store; drain transactions flush results owed after the last pixel.
// ----------------------------------------------------------------------------
module binary_cross_majority_filter #(
   parameter int MAX_WIDTH = bcmf_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bcmf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bcmf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [bcmf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bcmf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                     en;
   logic                     accept;
   logic [COL_W-1:0]         rd_col;
   logic                     s1_valid;
   bcmf_pkg::item_ctl_type   s1_ctl;
   logic [COL_W-1:0]         s1_col;
   logic                     mem_wr_en;
   bcmf_pkg::line_entry_type line_rd;
   bcmf_pkg::line_entry_type line_wr;

   // hold the whole pipeline while a result waits
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;
   assign mem_wr_en = s1_valid && en;

   bcmf_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .en        (en),
      .accept    (accept),
      .req_data  (req_data),
      .rd_col    (rd_col),
      .s1_valid  (s1_valid),
      .s1_ctl    (s1_ctl),
      .s1_col    (s1_col)
   );

   bcmf_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_col),
      .wr_en   (mem_wr_en),
      .wr_addr (s1_col),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   bcmf_vote u_vote (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .s1_valid  (s1_valid),
      .s1_ctl    (s1_ctl),
      .line_rd   (line_rd),
      .line_wr   (line_wr),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_no_write_while_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !mem_wr_en)
      else $error("line store written while the result is held");

   a_stall_only_on_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled without a waiting result");

   a_result_from_emitting_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(s1_valid && s1_ctl.emit))
      else $error("result appeared without an emitting transaction");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary cross majority filter. A queue-fed
// driver streams pixel and drain transactions, a monitor predicts every
// filtered pixel and scores the result stream in order, under random gaps
// and stalls on both sides, a long receiver hold-off and many frame sizes.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_W         = bcmf_pkg::DEFAULT_MAX_WIDTH;
   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 5;
   localparam int IDLE_PERCENT  = 37;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 8;
   localparam int SETTLE_LIMIT  = 50000;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PIXELS = 500;

   // 3 x 3 plus shape, top row first
   localparam logic [8:0] PLUS_PATTERN = 9'b010_101_010;

   typedef enum {TAIL_EXACT, TAIL_EXTRA, TAIL_MIXED, TAIL_NONE} tail_kind_type;

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   bcmf_pkg::req_type                req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   bcmf_pkg::rsp_type                rsp_data;
   logic                             csr_wr_en = 1'b0;
   logic [bcmf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bcmf_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   bcmf_pkg::req_type pending_items[$];
   bcmf_pkg::rsp_type expected_pixels[$];
   int unsigned items_pushed   = 0;
   int unsigned pixels_pushed  = 0;
   int unsigned items_accepted = 0;
   int unsigned pixels_checked = 0;
   int unsigned frames_closed  = 0;
   int unsigned reg_writes     = 0;
   int unsigned mismatch_count = 0;
   int unsigned leftover_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned hold_left      = 0;
   logic        req_accepted   = 1'b0;
   bit          steady         = 1'b0;
   bit          hold_request   = 1'b0;
   bit          hold_done      = 1'b0;
   int unsigned frame_w        = 1;
   int unsigned frame_h        = 1;

   // filter image: size registers, line stores, window and raster positions
   logic [bcmf_pkg::WIDTH_REG_W-1:0]  width_reg;
   logic [bcmf_pkg::HEIGHT_REG_W-1:0] height_reg;
   logic                    row_above [MAX_W];
   logic                    row_middle [MAX_W];
   logic [2:0]              column_taps [3];   // bit0 upper, bit1 middle, bit2 lower
   int unsigned             in_col, in_row, out_col, out_row;

   binary_cross_majority_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void restart_counters();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   function automatic void clear_filter_state();
      width_reg  = bcmf_pkg::RESET_IMAGE_WIDTH;
      height_reg = bcmf_pkg::RESET_IMAGE_HEIGHT;
      for (int i = 0; i < MAX_W; i++) begin
         row_above[i]  = 1'b0;
         row_middle[i] = 1'b0;
      end
      for (int i = 0; i < 3; i++) column_taps[i] = '0;
      restart_counters();
   endfunction

   // Advance the filter by one transaction; returns 1 when it yields a pixel.
   function automatic bit filter_step(input bcmf_pkg::req_type item,
                                      output bcmf_pkg::rsp_type res);
      int unsigned w, h, col, black, white;
      logic        pix, top_px, mid_px;
      logic [3:0]  present, votes;
      bit          past_end, emit;
      w = (width_reg == '0) ? 1 : 32'(width_reg);
      if (w > MAX_W) w = MAX_W;
      h = (height_reg == '0) ? 1 : 32'(height_reg);
      res = '0;
      past_end = in_row >= h;
      // drain before the last pixel: drop it
      if (item.cmd && !past_end) return 1'b0;
      pix    = (!item.cmd && !past_end) ? item.pixel_in : 1'b0;
      col    = in_col % MAX_W;
      top_px = row_above[col];
      mid_px = row_middle[col];
      row_above[col]  = mid_px;
      row_middle[col] = pix;
      column_taps[0] = column_taps[1];
      column_taps[1] = column_taps[2];
      column_taps[2] = {pix, mid_px, top_px};
      // results trail their pixel by one row and one column
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      if (emit) begin
         present = {out_row > 0, out_col > 0, out_row + 1 < h, out_col + 1 < w};
         votes   = {column_taps[1][0], column_taps[0][1], column_taps[1][2],
                    column_taps[2][1]};
         black = 0;
         white = 0;
         for (int i = 0; i < 4; i++) begin
            if (present[i]) begin
               if (votes[i]) black++;
               else white++;
            end
         end
         res.pixel_out    = (black > 2) ? 1'b1 : (white > 2) ? 1'b0 : column_taps[1][1];
         res.end_of_frame = (out_row + 1 >= h) && (out_col + 1 >= w);
      end
      if (emit && res.end_of_frame) begin
         restart_counters();
      end else begin
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (emit) begin
            out_col++;
            if (out_col >= w) begin
               out_col = 0;
               out_row++;
            end
         end
      end
      return emit;
   endfunction

   // monitor: score results, predict from accepted transactions, track writes
   always @(posedge clock) begin
      bcmf_pkg::rsp_type want;
      if (reset) begin
         clear_filter_state();
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel_out: expected none, actual %0b", rsp_data.pixel_out);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_out !== want.pixel_out) begin
                  $error("pixel_out: expected %0b, actual %0b",
                         want.pixel_out, rsp_data.pixel_out);
                  mismatch_count++;
               end
               if (rsp_data.end_of_frame !== want.end_of_frame) begin
                  $error("end_of_frame: expected %0b, actual %0b",
                         want.end_of_frame, rsp_data.end_of_frame);
                  mismatch_count++;
               end
               pixels_checked++;
               if (want.end_of_frame) frames_closed++;
            end
         end
         if (req_valid && !req_stall) begin
            items_accepted++;
            if (filter_step(req_data, want)) expected_pixels.push_back(want);
         end
         if (csr_wr_en) begin
            reg_writes++;
            if (csr_index == bcmf_pkg::CSR_IMAGE_WIDTH) begin
               width_reg = csr_wdata[bcmf_pkg::WIDTH_REG_W-1:0];
            end else if (csr_index == bcmf_pkg::CSR_IMAGE_HEIGHT) begin
               height_reg = csr_wdata;
            end
            restart_counters();
         end
      end
   end

   // driver: hold the offered transaction until taken, then maybe idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_data  <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off once results flow
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done && rsp_valid) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("cycle limit of %0d reached", CYCLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic void push_item(input logic cmd, input logic pixel);
      bcmf_pkg::req_type item;
      item.cmd      = cmd;
      item.pixel_in = pixel;
      pending_items.push_back(item);
      items_pushed++;
      if (!cmd) pixels_pushed++;
   endfunction

   // Wait for every transaction to be taken and every result to arrive.
   task automatic wait_idle();
      int unsigned waited;
      waited = 0;
      while ((items_accepted != items_pushed || expected_pixels.size() != 0) &&
             waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (items_accepted != items_pushed) begin
         $error("%0d transactions never accepted", items_pushed - items_accepted);
         leftover_count += items_pushed - items_accepted;
      end
      if (expected_pixels.size() != 0) begin
         $error("%0d filtered pixels never arrived", expected_pixels.size());
         leftover_count += expected_pixels.size();
         expected_pixels.delete();
      end
      // let transactions that owe no result leave the pipeline
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [bcmf_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bcmf_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic resize(input int unsigned wval, input int unsigned hval);
      int unsigned w11;
      wait_idle();
      write_reg(bcmf_pkg::CSR_IMAGE_WIDTH, bcmf_pkg::CSR_DATA_W'(wval));
      write_reg(bcmf_pkg::CSR_IMAGE_HEIGHT, bcmf_pkg::CSR_DATA_W'(hval));
      w11     = wval & ((1 << bcmf_pkg::WIDTH_REG_W) - 1);
      frame_w = (w11 == 0) ? 1 : (w11 > MAX_W) ? MAX_W : w11;
      frame_h = (hval == 0) ? 1 : hval;
   endtask

   task automatic send_frame(input int unsigned density, input tail_kind_type tail);
      for (int r = 0; r < frame_h; r++) begin
         for (int c = 0; c < frame_w; c++) begin
            if ($urandom_range(99) < 5) push_item(1'b1, 1'($urandom_range(1)));
            push_item(1'b0, $urandom_range(99) < density);
         end
      end
      case (tail)
         TAIL_EXACT: repeat (frame_w + 1) push_item(1'b1, 1'($urandom_range(1)));
         TAIL_EXTRA: repeat (frame_w + 1 + $urandom_range(1, 3)) push_item(1'b1, 1'b0);
         TAIL_MIXED: begin
            // stray pixels past the frame end stand in for drains
            repeat (frame_w + 1) push_item(1'($urandom_range(1)), 1'($urandom_range(1)));
         end
         default: ;
      endcase
   endtask

   initial begin
      int unsigned   frame_idx, start_px, wval, hval, pick, density;
      tail_kind_type tail;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a few pixels at the reset size, then abandon the frame by resizing
      repeat (6) push_item(1'b0, 1'($urandom_range(1)));

      // zero width and height act as a single pixel frame
      resize(0, 0);
      push_item(1'b1, 1'b1);
      push_item(1'b0, 1'b1);
      push_item(1'b0, 1'b0);
      push_item(1'b1, 1'b0);

      // plus shape: center turns black, edge pixels go white, corners hold
      resize(3, 3);
      for (int i = 8; i >= 0; i--) begin
         push_item(1'b0, PLUS_PATTERN[i]);
         if (i == 5) push_item(1'b1, 1'b1);
      end
      repeat (4) push_item(1'b1, 1'b0);

      start_px  = pixels_pushed;
      frame_idx = 0;
      while (pixels_pushed - start_px < RANDOM_PIXELS) begin
         steady = (frame_idx >= 5 && frame_idx < 12);
         if (frame_idx == 0 || $urandom_range(99) < 80) begin
            pick = $urandom_range(99);
            wval = (pick < 75) ? $urandom_range(1, 8) : (pick < 92) ? $urandom_range(9, 40) : 0;
            pick = $urandom_range(99);
            hval = (pick < 85) ? $urandom_range(1, 6) : (pick < 95) ? 0 : $urandom_range(7, 20);
            // junk above the width field must be ignored
            if ($urandom_range(99) < 10) wval |= $urandom_range(31) << bcmf_pkg::WIDTH_REG_W;
            resize(wval, hval);
         end
         case ($urandom_range(2))
            0:       density = 8;
            1:       density = 50;
            default: density = 92;
         endcase
         pick = $urandom_range(99);
         tail = (pick < 50) ? TAIL_EXACT : (pick < 65) ? TAIL_EXTRA :
                (pick < 80) ? TAIL_MIXED : TAIL_NONE;
         send_frame(density, tail);
         frame_idx++;
      end
      steady = 1'b0;

      // receiver holds off once results flow: the block must back up
      resize(40, 4);
      hold_request = 1'b1;
      send_frame(50, TAIL_EXACT);

      // width beyond the line store clamps to full width: run the first row
      // and part of the second, then cut the frame off
      resize((1 << bcmf_pkg::WIDTH_REG_W) - 1, 2);
      repeat (MAX_W + 40) push_item(1'b0, $urandom_range(99) < 92);

      // tallest frame: run a slice of it, then cut it off
      resize(2, (1 << bcmf_pkg::HEIGHT_REG_W) - 1);
      repeat (60) push_item(1'b0, 1'($urandom_range(1)));

      resize(1, 1);
      send_frame(50, TAIL_EXACT);
      wait_idle();

      $display("Streamed %0d transactions (%0d pixels) over %0d register writes.",
               items_accepted, pixels_pushed, reg_writes);
      $display("Checked %0d filtered pixels, %0d frames closed.",
               pixels_checked, frames_closed);
      if (mismatch_count == 0 && leftover_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
